// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the loop recorder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define NELR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that a trigger is followed by a condition in the next cycle.
`define NELR_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== hdl/nelr_pkg.sv =====
// Types and constants shared by the note event loop recorder modules.
package nelr_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned NOTE_W     = 8;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned REM_W      = 5;
  localparam int unsigned QUANT_STEP = 24;
  localparam int unsigned QUANT_HALF = 12;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_PLAY_TICK  = 3'd1,
    OP_FIRST_NOTE = 3'd2,
    OP_FIRST_NULL = 3'd3,
    OP_NOTE_START = 3'd4,
    OP_NOTE_STOP  = 3'd5,
    OP_STOP_REC   = 3'd6,
    OP_REWIND     = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } action_e;

  typedef struct packed {
    logic [TIME_W-1:0] ev_time;
    logic [NOTE_W-1:0] ev_note;
    kind_e             ev_kind;
  } entry_t;

  typedef struct packed {
    logic clr_we;
    logic accept;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_stat_t;

endpackage

// ===== hdl/nelr_ctrl.sv =====
// Controller state machine: clearing pass, item accept and result commit.
`include "assert_macros.svh"

module nelr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  nelr_pkg::dp_stat_t  stat_i,
  output nelr_pkg::ctrl_cmd_t cmd_o
);
  import nelr_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, commit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // The result may only be committed once the output register is free or being drained.
  assign commit     = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  assign cmd_o.clr_we = (state_q == ST_CLEAR);
  assign cmd_o.accept = accept;
  assign cmd_o.commit = commit;
  assign out_valid_o  = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `NELR_ASSERT_NEXT(a_accept_to_exec, accept, (state_q == ST_EXEC) && !in_ready_o, "accept did not enter exec")
  `NELR_ASSERT_ALWAYS(a_clear_no_result, (state_q != ST_CLEAR) || !out_valid_q, "result during clear")
  `NELR_ASSERT_NEXT(a_commit_valid, commit, out_valid_q, "committed result not presented")

endmodule

// ===== hdl/nelr_dp.sv =====
// Datapath: event memory, loop time and index registers, rounding and result registers.
`include "assert_macros.svh"

module nelr_dp #(
  parameter int EVENT_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nelr_pkg::ctrl_cmd_t cmd_i,
  output nelr_pkg::dp_stat_t  stat_o,
  input  logic                cfg_wen_i,
  input  logic                cfg_wdata_i,
  input  logic [2:0]          op_i,
  input  logic [7:0]          note_in_i,
  input  logic                keys_held_i,
  output logic [1:0]          action_o,
  output logic [7:0]          note_out_o,
  output logic [7:0]          position_o,
  output logic                store_full_o
);
  import nelr_pkg::*;

  localparam int IW = $clog2(EVENT_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(EVENT_DEPTH - 1);

  entry_t            mem [EVENT_DEPTH];
  entry_t            rd_q;
  logic [IW-1:0]     rd_addr;
  logic              mem_we;
  logic [IW-1:0]     mem_wa;
  entry_t            mem_wd;

  logic [IW-1:0]     clr_cnt_q;
  logic              quant_q;
  logic [IW-1:0]     index_q, index_d;
  logic [IW-1:0]     length_q, length_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic [REM_W-1:0]  rem_q, rem_d;

  op_e               op_q;
  logic [NOTE_W-1:0] note_q;
  logic              keys_q;
  logic [TIME_W-1:0] qtime_q, qtime_d;
  logic [TIME_W-1:0] down;
  logic              round_up;

  logic              wr_en;
  logic [IW-1:0]     wr_idx;
  entry_t            wr_ent;
  action_e           act;
  logic [NOTE_W-1:0] nout;
  logic              full;
  logic [IW:0]       idx_inc;

  logic [1:0]        action_q;
  logic [NOTE_W-1:0] note_out_q;
  logic [POS_W-1:0]  position_q;
  logic              full_q;

  // Stop recording needs entry 0's note; every other item reads the entry at the index.
  assign rd_addr = (op_e'(op_i) == OP_STOP_REC) ? '0 : index_q;

  // rem_q tracks the loop time modulo the quantize step, so rounding needs no divider.
  assign down     = time_q - TIME_W'(rem_q);
  assign round_up = (rem_q > REM_W'(QUANT_HALF)) && (down <= ('1 - TIME_W'(QUANT_STEP)));
  always_comb begin
    if (!quant_q) begin
      qtime_d = time_q;
    end else if (round_up) begin
      qtime_d = down + TIME_W'(QUANT_STEP);
    end else begin
      qtime_d = down;
    end
  end

  always_comb begin
    index_d  = index_q;
    time_d   = time_q;
    rem_d    = rem_q;
    length_d = length_q;
    wr_en    = 1'b0;
    wr_idx   = index_q;
    wr_ent   = '{ev_time: time_q, ev_note: note_q, ev_kind: KIND_NONE};
    act      = ACT_NONE;
    nout     = '0;
    full     = 1'b0;
    idx_inc  = {1'b0, index_q} + 1'b1;
    unique case (op_q)
      OP_TICK: begin
        time_d = time_q + 1'b1;
        if (time_q == '1 || rem_q == REM_W'(QUANT_STEP - 1)) begin
          rem_d = '0;
        end else begin
          rem_d = rem_q + 1'b1;
        end
      end
      OP_PLAY_TICK: begin
        if (time_q >= rd_q.ev_time) begin
          if (!keys_q) begin
            if (rd_q.ev_kind == KIND_START) begin
              act  = ACT_START;
              nout = rd_q.ev_note;
            end else if (rd_q.ev_kind == KIND_STOP) begin
              act = ACT_STOP;
            end
          end
          if (idx_inc > {1'b0, length_q} || index_q == LAST_IDX) begin
            index_d = '0;
            time_d  = '0;
            rem_d   = '0;
          end else begin
            index_d = idx_inc[IW-1:0];
          end
        end
      end
      OP_FIRST_NOTE, OP_FIRST_NULL: begin
        wr_en    = 1'b1;
        wr_idx   = '0;
        wr_ent   = (op_q == OP_FIRST_NOTE)
                   ? entry_t'{ev_time: '0, ev_note: note_q, ev_kind: KIND_START}
                   : entry_t'{ev_time: '0, ev_note: '0, ev_kind: KIND_NONE};
        time_d   = '0;
        rem_d    = '0;
        length_d = '0;
        index_d  = IW'(1);
      end
      OP_NOTE_START, OP_NOTE_STOP: begin
        // The last entry is kept free for the loop-end marker.
        if (index_q >= LAST_IDX) begin
          full = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_ent  = '{ev_time: time_q, ev_note: note_q,
                      ev_kind: (op_q == OP_NOTE_START) ? KIND_START : KIND_STOP};
          index_d = idx_inc[IW-1:0];
        end
      end
      OP_STOP_REC: begin
        wr_en    = 1'b1;
        wr_ent   = '{ev_time: qtime_q, ev_note: rd_q.ev_note, ev_kind: KIND_END};
        length_d = index_q;
        index_d  = '0;
        time_d   = '0;
        rem_d    = '0;
        act      = ACT_STOP;
      end
      OP_REWIND: begin
        index_d = '0;
        time_d  = '0;
        rem_d   = '0;
      end
    endcase
  end

  assign mem_we = cmd_i.clr_we || (cmd_i.commit && wr_en);
  assign mem_wa = cmd_i.clr_we ? clr_cnt_q : wr_idx;
  assign mem_wd = cmd_i.clr_we ? '0 : wr_ent;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.accept) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign stat_o.clear_last = (clr_cnt_q == LAST_IDX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      quant_q   <= 1'b0;
      index_q   <= '0;
      length_q  <= '0;
      time_q    <= '0;
      rem_q     <= '0;
    end else begin
      if (cmd_i.clr_we) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cfg_wen_i) begin
        quant_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        index_q  <= index_d;
        length_q <= length_d;
        time_q   <= time_d;
        rem_q    <= rem_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= op_e'(op_i);
      note_q  <= note_in_i;
      keys_q  <= keys_held_i;
      qtime_q <= qtime_d;
    end
    if (cmd_i.commit) begin
      action_q   <= act;
      note_out_q <= nout;
      position_q <= POS_W'(index_d);
      full_q     <= full;
    end
  end

  assign action_o     = action_q;
  assign note_out_o   = note_out_q;
  assign position_o   = position_q;
  assign store_full_o = full_q;

  `NELR_ASSERT_ALWAYS(a_index_range, index_q <= LAST_IDX, "event index past the store")
  `NELR_ASSERT_ALWAYS(a_length_range, length_q <= LAST_IDX, "loop length past the store")
  `NELR_ASSERT_ALWAYS(a_rem_range, rem_q < REM_W'(QUANT_STEP), "time remainder out of range")

endmodule

// ===== hdl/note_event_loop_recorder_core.sv =====
// Top level of the note event loop recorder: controller and datapath.
//
//  Channel  | Signals                                   | Direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid_i/in_ready_o, op, note_in, keys  | into block
//  out      | out_valid_o/out_ready_i, action, note_out,| out of block
//           | position, store_full                      |
//  cfg      | cfg_wen_i, cfg_wdata_i (quantize enable)  | into block
//
// For each item the accept cycle registers the event memory read; the exec
// state then updates the state, writes the memory and loads the result.
// After reset a clearing pass writes zero to all EVENT_DEPTH entries, one per
// cycle, with in_ready_o low; configuration writes are taken throughout.
// A result waits in the output register; the next item is accepted meanwhile
// and holds in the exec state until the output register is drained.
module note_event_loop_recorder_core #(
  parameter int EVENT_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_wen_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] op_i,
  input  logic [7:0] note_in_i,
  input  logic       keys_held_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] action_o,
  output logic [7:0] note_out_o,
  output logic [7:0] position_o,
  output logic       store_full_o
);
  import nelr_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  nelr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  nelr_dp #(
    .EVENT_DEPTH (EVENT_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_wen_i    (cfg_wen_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .op_i         (op_i),
    .note_in_i    (note_in_i),
    .keys_held_i  (keys_held_i),
    .action_o     (action_o),
    .note_out_o   (note_out_o),
    .position_o   (position_o),
    .store_full_o (store_full_o)
  );

endmodule
